// ===== hdl/dht_pkg.sv =====
`default_nettype none

package dht_pkg;

   // defaults for the top-level parameters
   localparam int TABLE_SIZE_DEF  = 31;
   localparam int STEP_PRIME_DEF  = 17;
   localparam int KEY_WIDTH_DEF   = 16;
   localparam int VALUE_WIDTH_DEF = 32;

   // result field widths are fixed
   localparam int SLOT_W   = 5;
   localparam int PROBES_W = 5;
   localparam int RSP_DW   = ((SLOT_W + PROBES_W + 7) / 8) * 8;

   localparam logic MODE_INSERT = 1'b0;
   localparam logic MODE_REMOVE = 1'b1;

   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

endpackage

`default_nettype wire

// ===== hdl/dht_ram.sv =====
`default_nettype none

module dht_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 31
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== hdl/dht_modadd.sv =====
`default_nettype none

// (a + b + cin) mod M, for a, b < M
module dht_modadd #(
   parameter int M = 31
) (
   input  wire logic [$clog2(M)-1:0] a,
   input  wire logic [$clog2(M)-1:0] b,
   input  wire logic                 cin,
   output logic      [$clog2(M)-1:0] sum
);

   localparam int W = $clog2(M);

   logic [W:0] raw;

   always_comb begin
      raw = {1'b0, a} + {1'b0, b} + (W + 1)'(cin);
      if (raw >= (W + 1)'(M)) begin
         sum = W'(raw - (W + 1)'(M));
      end else begin
         sum = raw[W-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== hdl/double_hash_table_core.sv =====
`default_nettype none

// channel | dir | beat contents
// req_    | in  | tdata: key, value (low bit up); tuser: mode
// rsp_    | out | tdata: slot, probes_used (low bit up); tuser: status
//
// One request at a time; a request takes 1..TABLE_SIZE probes.
// Key mod TABLE_SIZE and STEP_PRIME, then step mod TABLE_SIZE, by reciprocal multiply:
// a quotient state then a remainder state each, the TABLE_SIZE unit shared.
// Each probe then costs one key-memory read and one pass through the modular adder.
// Synchronous reset empties the table (valid bits) and the result valid flag.
// A finished result waits in its register; the sequencer holds if that is still full.
module double_hash_table_core #(
   parameter int TABLE_SIZE  = dht_pkg::TABLE_SIZE_DEF,
   parameter int STEP_PRIME  = dht_pkg::STEP_PRIME_DEF,
   parameter int KEY_WIDTH   = dht_pkg::KEY_WIDTH_DEF,
   parameter int VALUE_WIDTH = dht_pkg::VALUE_WIDTH_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_tvalid,
   output logic      req_tready,
   // key, value
   input  wire logic [((KEY_WIDTH + VALUE_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   // mode
   input  wire logic req_tuser,
   output logic      rsp_tvalid,
   input  wire logic rsp_tready,
   // slot, probes_used
   output logic [dht_pkg::RSP_DW-1:0] rsp_tdata,
   // status
   output logic rsp_tuser
);

   localparam int TW   = $clog2(TABLE_SIZE);
   localparam int SRW  = $clog2(STEP_PRIME);
   localparam int SW   = $clog2(STEP_PRIME + 1);
   localparam int NMAX = (KEY_WIDTH > SW) ? KEY_WIDTH : SW;
   localparam int XW   = (TW + 1 > dht_pkg::SLOT_W) ? TW + 1 : dht_pkg::SLOT_W;

   // floor(x / d) = (x * ceil(2^(N+L) / d)) >> (N+L) for x < 2^N, L = clog2(d)
   localparam int SHT = NMAX + TW;
   localparam int SHS = NMAX + SRW;
   localparam int PWT = SHT + NMAX;
   localparam int PWS = SHS + NMAX;
   localparam logic [63:0] RECIP_T =
      ((64'd1 << SHT) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
   localparam logic [63:0] RECIP_S =
      ((64'd1 << SHS) + 64'(STEP_PRIME) - 64'd1) / 64'(STEP_PRIME);
   localparam logic [NMAX-1:0] T_N = NMAX'(TABLE_SIZE);
   localparam logic [NMAX-1:0] S_N = NMAX'(STEP_PRIME);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_DIV   = 6'b000010,
      ST_REM   = 6'b000100,
      ST_SDIV  = 6'b001000,
      ST_SREM  = 6'b010000,
      ST_CHECK = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic                   mode_ff, mode_in;
   logic [KEY_WIDTH-1:0]   key_ff, key_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [NMAX-1:0]        qt_ff, qt_in;
   logic [NMAX-1:0]        qs_ff, qs_in;
   logic [SW-1:0]          step_ff, step_in;
   logic [TW-1:0]          stept_ff, stept_in;
   logic [TW-1:0]          idx_ff, idx_in;
   logic [TW-1:0]          j_ff, j_in;
   logic [TABLE_SIZE-1:0]  valid_ff, valid_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [dht_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [dht_pkg::PROBES_W-1:0] probes_ff, probes_in;
   logic                        status_ff, status_in;

   logic [TW-1:0]        t_sum;
   logic [NMAX-1:0]      key_n, opd_x, qt_w, qs_w, rem_t, rem_s;
   logic                 step_sel;
   logic [TW-1:0]        rd_addr;
   logic [KEY_WIDTH-1:0] key_rd;
   logic                 hit, last, done, out_free, ram_we;
   logic [XW-1:0]        idx_x, probes_x;

   // probe advance: (idx + step) mod TABLE_SIZE
   dht_modadd #(.M(TABLE_SIZE)) u_tadd (
      .a   (idx_ff),
      .b   (stept_ff),
      .cin (1'b0),
      .sum (t_sum)
   );

   dht_ram #(.WIDTH(KEY_WIDTH), .DEPTH(TABLE_SIZE)) u_key_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (key_ff),
      .rd_addr (rd_addr),
      .rd_data (key_rd)
   );

   dht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(TABLE_SIZE)) u_value_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (idx_ff),
      .wr_data (value_ff),
      .rd_addr (idx_ff),
      .rd_data ()
   );

   // shared mod TABLE_SIZE unit works on the key first, then on the step
   assign key_n    = NMAX'(key_ff);
   assign step_sel = (state_ff == ST_SDIV) || (state_ff == ST_SREM);
   assign opd_x    = step_sel ? NMAX'(step_ff) : key_n;
   assign qt_w     = NMAX'((PWT'(opd_x) * PWT'(RECIP_T)) >> SHT);
   assign qs_w     = NMAX'((PWS'(key_n) * PWS'(RECIP_S)) >> SHS);
   assign rem_t    = opd_x - qt_ff * T_N;
   assign rem_s    = key_n - qs_ff * S_N;

   assign hit      = !valid_ff[idx_ff] || (key_rd == key_ff);
   assign last     = (j_ff == TW'(TABLE_SIZE - 1));
   assign done     = hit || last;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign ram_we   = (state_ff == ST_CHECK) && hit && out_free
                     && (mode_ff == dht_pkg::MODE_INSERT);
   // look ahead to the next slot, so its key is read while this slot is checked
   assign rd_addr  = ((state_ff == ST_CHECK) && !done) ? t_sum : idx_ff;
   assign idx_x    = XW'(idx_ff);
   assign probes_x = XW'(j_ff) + XW'(1);

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      qt_in        = qt_ff;
      qs_in        = qs_ff;
      step_in      = step_ff;
      stept_in     = stept_ff;
      idx_in       = idx_ff;
      j_in         = j_ff;
      valid_in     = valid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      slot_in      = slot_ff;
      status_in    = status_ff;
      probes_in    = probes_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in  = req_tuser;
               key_in   = req_tdata[KEY_WIDTH-1:0];
               value_in = req_tdata[KEY_WIDTH+VALUE_WIDTH-1:KEY_WIDTH];
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            qt_in    = qt_w;
            qs_in    = qs_w;
            state_in = ST_REM;
         end
         ST_REM: begin
            // home slot, and step = STEP_PRIME - key mod STEP_PRIME
            idx_in   = TW'(rem_t);
            step_in  = SW'(STEP_PRIME) - SW'(rem_s);
            j_in     = '0;
            state_in = ST_SDIV;
         end
         ST_SDIV: begin
            qt_in    = qt_w;
            state_in = ST_SREM;
         end
         ST_SREM: begin
            // step mod TABLE_SIZE; key memory is reading the home slot meanwhile
            stept_in = TW'(rem_t);
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (!done) begin
               idx_in = t_sum;
               j_in   = j_ff + TW'(1);
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               if (hit) begin
                  valid_in[idx_ff] = (mode_ff == dht_pkg::MODE_INSERT);
                  slot_in          = idx_x[dht_pkg::SLOT_W-1:0];
                  status_in        = dht_pkg::STATUS_DONE;
                  probes_in        = probes_x[dht_pkg::PROBES_W-1:0];
               end else begin
                  slot_in   = '0;
                  status_in = dht_pkg::STATUS_FULL;
                  probes_in = dht_pkg::PROBES_W'(TABLE_SIZE);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff   <= mode_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      qt_ff     <= qt_in;
      qs_ff     <= qs_in;
      step_ff   <= step_in;
      stept_ff  <= stept_in;
      idx_ff    <= idx_in;
      j_ff      <= j_in;
      slot_ff   <= slot_in;
      status_ff <= status_in;
      probes_ff <= probes_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = status_ff;
   assign rsp_tdata  = dht_pkg::RSP_DW'({probes_ff, slot_ff});

endmodule

`default_nettype wire
